/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check prop on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that cond never holds on a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

/* hw/rtl/sha1_pkg.sv */
// Types, constants and round functions of the SHA-1 hasher.
package sha1_pkg;

  typedef logic [31:0] word_t;
  typedef logic [6:0]  rnd_t;
  typedef logic [5:0]  pos_t;
  typedef logic [60:0] count_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_FOLD,
    S_DONE
  } state_t;

  localparam int   ChainWords  = 5;
  localparam int   WindowWords = 16;
  localparam rnd_t RoundLast   = 7'd79;
  localparam rnd_t RoundWin    = 7'd16;
  localparam pos_t PosLast     = 6'd63;
  localparam pos_t PosLength   = 6'd56;
  localparam logic [7:0] PadMark = 8'h80;

  localparam word_t HInit [ChainWords] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  function automatic word_t round_k(input rnd_t t);
    word_t k;
    case (t) inside
      [7'd0:7'd19]:  k = 32'h5A827999;
      [7'd20:7'd39]: k = 32'h6ED9EBA1;
      [7'd40:7'd59]: k = 32'h8F1BBCDC;
      default:       k = 32'hCA62C1D6;
    endcase
    return k;
  endfunction

  function automatic word_t round_f(input rnd_t t, input word_t b, input word_t c,
                                    input word_t d);
    word_t f;
    case (t) inside
      [7'd0:7'd19]:  f = (b & c) | (~b & d);
      [7'd40:7'd59]: f = (b & c) | (b & d) | (c & d);
      default:       f = b ^ c ^ d;
    endcase
    return f;
  endfunction

endpackage

/* hw/rtl/sha1_stream_hasher.sv */
// SHA-1 stream hasher: byte input, padding and 160-bit digest output.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid, in_stall, in_data_byte,       | in
//           | in_byte_valid, in_last                  |
//   out     | out_valid, out_stall, out_hash_word_0..4| out
//
// A byte that does not finish a block leaves the hasher idle for the next
// byte. A byte that finishes a block starts compression: one round per cycle
// through the single round adder, then a fold into the chaining words. A last
// item adds pad bytes (to 64 or 128 bytes total), runs the same compression
// per padded block and loads the digest register. Reset (rst_n low) loads
// the initial chaining words and clears the count. The digest waits in its
// output register while out_stall is high; the next message streams in.
`include "assert_macros.svh"

module sha1_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_hash_word_0,
  output logic [31:0] out_hash_word_1,
  output logic [31:0] out_hash_word_2,
  output logic [31:0] out_hash_word_3,
  output logic [31:0] out_hash_word_4
);

  sha1_pkg::state_t state_r, state_nxt;
  sha1_pkg::rnd_t   rnd_r, rnd_nxt;
  sha1_pkg::pos_t   pos_r, pos_nxt;
  sha1_pkg::count_t cnt_r, cnt_nxt, cnt_after;
  sha1_pkg::word_t  chain_r [sha1_pkg::ChainWords];
  sha1_pkg::word_t  chain_nxt [sha1_pkg::ChainWords];
  sha1_pkg::word_t  v_r [sha1_pkg::ChainWords];
  sha1_pkg::word_t  v_nxt [sha1_pkg::ChainWords];
  sha1_pkg::word_t  win_r [sha1_pkg::WindowWords];
  sha1_pkg::word_t  win_nxt [sha1_pkg::WindowWords];
  sha1_pkg::word_t  hash_r [sha1_pkg::ChainWords];
  sha1_pkg::word_t  hash_nxt [sha1_pkg::ChainWords];
  logic [23:0]      acc_r, acc_nxt;
  logic [63:0]      len_r, len_nxt;
  logic             pad_r, pad_nxt;
  logic             first_r, first_nxt;
  logic             lenph_r, lenph_nxt;
  logic             fin_r, fin_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             push;
  logic [7:0]       push_byte;
  logic             shift_win;
  sha1_pkg::word_t  shift_word;
  sha1_pkg::word_t  sched_w;
  sha1_pkg::word_t  round_sum;
  logic             len_byte;

  assign in_stall        = (state_r != sha1_pkg::S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_hash_word_0 = hash_r[0];
  assign out_hash_word_1 = hash_r[1];
  assign out_hash_word_2 = hash_r[2];
  assign out_hash_word_3 = hash_r[3];
  assign out_hash_word_4 = hash_r[4];

  // Message schedule and the shared round adder.
  always_comb begin
    if (rnd_r < sha1_pkg::RoundWin) begin
      sched_w = win_r[0];
    end else begin
      sched_w = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
      sched_w = {sched_w[30:0], sched_w[31]};
    end
    round_sum = {v_r[0][26:0], v_r[0][31:27]}
              + sha1_pkg::round_f(rnd_r, v_r[1], v_r[2], v_r[3])
              + v_r[4] + sha1_pkg::round_k(rnd_r) + sched_w;
  end

  always_comb begin
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    chain_nxt     = chain_r;
    v_nxt         = v_r;
    win_nxt       = win_r;
    hash_nxt      = hash_r;
    acc_nxt       = acc_r;
    len_nxt       = len_r;
    pad_nxt       = pad_r;
    first_nxt     = first_r;
    lenph_nxt     = lenph_r;
    fin_nxt       = fin_r;
    out_valid_nxt = out_valid_r;
    push          = 1'b0;
    push_byte     = 8'h00;
    shift_win     = 1'b0;
    shift_word    = sched_w;
    len_byte      = 1'b0;
    cnt_after     = in_byte_valid ? cnt_r + 61'd1 : cnt_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      sha1_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_byte_valid) begin
            push      = 1'b1;
            push_byte = in_data_byte;
            cnt_nxt   = cnt_after;
          end
          if (in_last) begin
            pad_nxt   = 1'b1;
            first_nxt = 1'b1;
            lenph_nxt = 1'b0;
            fin_nxt   = 1'b0;
            len_nxt   = {cnt_after, 3'b000};
          end
          if (in_byte_valid && pos_r == sha1_pkg::PosLast) begin
            state_nxt = sha1_pkg::S_ROUND;
          end else if (in_last) begin
            state_nxt = sha1_pkg::S_PAD;
          end
        end
      end
      sha1_pkg::S_PAD: begin
        push      = 1'b1;
        first_nxt = 1'b0;
        len_byte  = !first_r && (lenph_r || pos_r == sha1_pkg::PosLength);
        if (first_r) begin
          push_byte = sha1_pkg::PadMark;
        end else if (len_byte) begin
          push_byte = len_r[63:56];
          len_nxt   = {len_r[55:0], 8'h00};
          lenph_nxt = 1'b1;
          if (pos_r == sha1_pkg::PosLast) begin
            fin_nxt = 1'b1;
          end
        end
        if (pos_r == sha1_pkg::PosLast) begin
          state_nxt = sha1_pkg::S_ROUND;
        end
      end
      sha1_pkg::S_ROUND: begin
        shift_win = 1'b1;
        v_nxt[0]  = round_sum;
        v_nxt[1]  = v_r[0];
        v_nxt[2]  = {v_r[1][1:0], v_r[1][31:2]};
        v_nxt[3]  = v_r[2];
        v_nxt[4]  = v_r[3];
        rnd_nxt   = rnd_r + 7'd1;
        if (rnd_r == sha1_pkg::RoundLast) begin
          state_nxt = sha1_pkg::S_FOLD;
        end
      end
      sha1_pkg::S_FOLD: begin
        for (int i = 0; i < sha1_pkg::ChainWords; i++) begin
          chain_nxt[i] = chain_r[i] + v_r[i];
        end
        if (!pad_r) begin
          state_nxt = sha1_pkg::S_IDLE;
        end else if (fin_r) begin
          state_nxt = sha1_pkg::S_DONE;
        end else begin
          state_nxt = sha1_pkg::S_PAD;
        end
      end
      sha1_pkg::S_DONE: begin
        // Hold the digest until the output register is free.
        if (!out_valid_r || !out_stall) begin
          hash_nxt      = chain_r;
          out_valid_nxt = 1'b1;
          chain_nxt     = sha1_pkg::HInit;
          cnt_nxt       = '0;
          pad_nxt       = 1'b0;
          fin_nxt       = 1'b0;
          lenph_nxt     = 1'b0;
          state_nxt     = sha1_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sha1_pkg::S_IDLE;
      end
    endcase

    // Byte entry: gather four bytes into a word, push it into the window.
    if (push) begin
      pos_nxt = pos_r + 6'd1;
      acc_nxt = {acc_r[15:0], push_byte};
      if (pos_r[1:0] == 2'd3) begin
        shift_win  = 1'b1;
        shift_word = {acc_r, push_byte};
      end
      if (pos_r == sha1_pkg::PosLast) begin
        v_nxt   = chain_r;
        rnd_nxt = '0;
      end
    end

    if (shift_win) begin
      for (int i = 0; i < sha1_pkg::WindowWords - 1; i++) begin
        win_nxt[i] = win_r[i + 1];
      end
      win_nxt[sha1_pkg::WindowWords - 1] = shift_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sha1_pkg::S_IDLE;
      rnd_r       <= '0;
      pos_r       <= '0;
      cnt_r       <= '0;
      chain_r     <= sha1_pkg::HInit;
      pad_r       <= 1'b0;
      first_r     <= 1'b0;
      lenph_r     <= 1'b0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      chain_r     <= chain_nxt;
      pad_r       <= pad_nxt;
      first_r     <= first_nxt;
      lenph_r     <= lenph_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r    <= v_nxt;
    win_r  <= win_nxt;
    hash_r <= hash_nxt;
    acc_r  <= acc_nxt;
    len_r  <= len_nxt;
  end

  `ASSERT_CLK(a_round_on_boundary, clk, rst_n, (state_r == sha1_pkg::S_ROUND && rnd_r == '0) |-> (pos_r == '0), "compression started off a block boundary")
  `ASSERT_CLK(a_fold_after_last_round, clk, rst_n, (state_r == sha1_pkg::S_FOLD) |-> ($past(state_r == sha1_pkg::S_ROUND) && $past(rnd_r == sha1_pkg::RoundLast)), "fold without a full set of rounds")
  `ASSERT_CLK(a_digest_from_done, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == sha1_pkg::S_DONE), "digest loaded outside the done state")
  `ASSERT_NEVER(a_pad_empty_block, clk, rst_n, (state_r == sha1_pkg::S_DONE) && (pos_r != '0 || !lenph_r), "digest taken before the length block finished")

endmodule
